// ===== rtl/core/pst_pkg.sv =====
// shared types and constants for the packet sequence tracker
// no dependencies; imported by pst_update and packet_sequence_tracker_top
package pst_pkg;

    // configuration register indexes
    localparam int unsigned CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] REG_GAP_LIMIT        = 1'b0;
    localparam logic [CfgIndexWidth-1:0] REG_RESYNC_THRESHOLD = 1'b1;
    localparam int unsigned CfgDataWidth = 8;

    // reset values of the configuration registers
    localparam logic [7:0] GAP_LIMIT_RESET        = 8'd5;
    localparam logic [3:0] RESYNC_THRESHOLD_RESET = 4'd5;

    // status codes
    localparam logic [2:0] ST_FIRST    = 3'd0;
    localparam logic [2:0] ST_IN_ORDER = 3'd1;
    localparam logic [2:0] ST_GAP      = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_RESYNC   = 3'd4;

    typedef struct packed {
        logic [31:0] sequence_number;
        logic [11:0] payload_length;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  gap_dropped;
        logic [31:0] total_packets;
        logic [31:0] good_total;
        logic [31:0] dropped_total;
        logic [31:0] error_total;
        logic [31:0] resync_total;
        logic [63:0] byte_total;
    } result_t;

    typedef struct packed {
        logic [31:0] last_seq;
        logic [31:0] last_good_seq;
        logic [4:0]  error_run;
        logic [31:0] packet_count;
        logic [31:0] good_count;
        logic [31:0] dropped_count;
        logic [31:0] error_count;
        logic [31:0] resync_count;
        logic [63:0] byte_count;
    } tracker_state_t;

    typedef struct packed {
        logic [7:0] gap_limit;
        logic [3:0] resync_threshold;
    } tracker_cfg_t;

endpackage

// ===== rtl/core/pst_update.sv =====
// classification and counter update for one word
// depends on pst_pkg
module pst_update (
    input  pst_pkg::item_t          item,
    input  pst_pkg::tracker_state_t state,
    input  pst_pkg::tracker_cfg_t   cfg,
    output pst_pkg::tracker_state_t state_next,
    output pst_pkg::result_t        result
);
    import pst_pkg::*;

    logic [31:0] seq;
    logic [31:0] diff;
    logic [31:0] dropped_now;
    logic [4:0]  run_inc;
    logic        is_first;
    logic        in_order;
    logic        ahead;
    logic        gap_ok;
    logic        resync;

    assign seq      = item.sequence_number;
    assign diff     = seq - state.last_good_seq;
    assign is_first = (state.packet_count == 32'd0);
    assign in_order = (seq == state.last_seq + 32'd1);
    assign ahead    = (seq > state.last_good_seq);
    assign gap_ok   = ahead && (diff < {24'd0, cfg.gap_limit});
    assign run_inc  = state.error_run + 5'd1;
    assign resync   = (run_inc > {1'b0, cfg.resync_threshold});

    always_comb
    begin
        state_next  = state;
        dropped_now = 32'd0;
        result.status = ST_FIRST;

        if (is_first)
        begin
            state_next.last_good_seq = seq;
            result.status = ST_FIRST;
        end
        else if (in_order)
        begin
            state_next.good_count    = state.good_count + 32'd1;
            state_next.error_run     = 5'd0;
            state_next.last_good_seq = seq;
            result.status = ST_IN_ORDER;
        end
        else if (gap_ok)
        begin
            dropped_now              = diff - 32'd1;
            state_next.dropped_count = state.dropped_count + dropped_now;
            state_next.error_run     = 5'd0;
            state_next.last_good_seq = seq;
            result.status = ST_GAP;
        end
        else
        begin
            state_next.error_count = state.error_count + 32'd1;
            if (resync)
            begin
                state_next.error_run     = 5'd0;
                state_next.last_good_seq = seq;
                state_next.resync_count  = state.resync_count + 32'd1;
                result.status = ST_RESYNC;
            end
            else
            begin
                state_next.error_run = run_inc;
                result.status = ST_REJECT;
            end
        end

        state_next.last_seq     = seq;
        state_next.packet_count = state.packet_count + 32'd1;
        state_next.byte_count   = state.byte_count + {52'd0, item.payload_length};

        // accepted gaps are below 255, so the drop count fits in eight bits
        result.gap_dropped   = dropped_now[7:0];
        result.total_packets = state_next.packet_count;
        result.good_total    = state_next.good_count;
        result.dropped_total = state_next.dropped_count;
        result.error_total   = state_next.error_count;
        result.resync_total  = state_next.resync_count;
        result.byte_total    = state_next.byte_count;
    end

endmodule

// ===== rtl/core/packet_sequence_tracker_top.sv =====
// top level of the packet sequence tracker: word registers, state, config
// depends on pst_pkg and pst_update
//
//  port group                      | dir | meaning
//  --------------------------------+-----+---------------------------------------
//  item_valid/item_ready/item      | in  | one received packet: sequence, length
//  result_valid/result_ready/result| out | status, drop count and all counters
//  cfg_write/cfg_index/cfg_data    | in  | register write, no wait, no read-back
//
// each word is held in the input register, then the update logic writes the
// state and the result register at the same edge; one word per cycle is
// sustained unless the result stalls, set by the single state update path.
// reset clears the valid flags, all counters and history, and loads the
// register defaults (gap limit 5, resync threshold 5).
// a stalled result holds the input register, and the input side then stalls.
module packet_sequence_tracker_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  pst_pkg::item_t                       item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output pst_pkg::result_t                     result,
    input  logic                                 cfg_write,
    input  logic [pst_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [pst_pkg::CfgDataWidth-1:0]     cfg_data
);
    import pst_pkg::*;

    // input register
    item_t          item_reg;
    logic           item_valid_reg;

    // result register
    result_t        result_reg;
    logic           result_valid_reg;

    // tracker state and configuration
    tracker_state_t state_reg;
    tracker_state_t state_next;
    tracker_cfg_t   cfg_reg;
    result_t        result_next;

    logic           advance;

    // a word moves on when the result register is empty or being drained
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    pst_update u_update (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // state commits exactly once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_limit        <= GAP_LIMIT_RESET;
            cfg_reg.resync_threshold <= RESYNC_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAP_LIMIT:        cfg_reg.gap_limit        <= cfg_data;
                REG_RESYNC_THRESHOLD: cfg_reg.resync_threshold <= cfg_data[3:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
